@@ rtl/list_mean_range_normalizer_assert.svh @@
// Assertion macros for the list mean/range normalizer checker.
// Depends on a clock named clock and a reset named reset in the using scope.
`ifndef LIST_MEAN_RANGE_NORMALIZER_ASSERT_SVH
`define LIST_MEAN_RANGE_NORMALIZER_ASSERT_SVH

// Checks an implication in the same cycle, outside reset.
`define LMRN_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks an implication in the next cycle, outside reset.
`define LMRN_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Checks an implication with no reset qualification.
`define LMRN_ASSERT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |-> (cons)) \
      else $error(msg);

`endif

@@ rtl/lmrn_pkg.sv @@
// Shared types and constants of the list mean/range normalizer.
// Used by every module of the block; depends on nothing.
package lmrn_pkg;

   // Capacity of the list and width of one sample.
   localparam int MAX_LEN     = 64;
   localparam int SAMPLE_BITS = 16;

   // Derived widths.
   localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CNT_W  = $clog2(MAX_LEN + 1);
   localparam int SUM_W  = SAMPLE_BITS + ADDR_W + 1;
   localparam int DEV_W  = SAMPLE_BITS + ADDR_W;
   localparam int NUM_W  = DEV_W + 1;

   // Result format: unsigned Q0.16, quotient carries one guard bit for saturation.
   localparam int NORM_W     = 16;
   localparam int QUOT_W     = NORM_W + 1;
   localparam int FRAC_SHIFT = NORM_W - 1;
   localparam int STEP_W     = $clog2(QUOT_W);

   localparam logic [NORM_W-1:0] NORM_MID = NORM_W'(1) << (NORM_W - 1);

   // Request codes.
   localparam logic REQ_PUSH   = 1'b0;
   localparam logic REQ_REPLAY = 1'b1;

   typedef struct packed {
      logic                          req_type;
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          last_flag;
   } req_payload_type;

   typedef struct packed {
      logic [NORM_W-1:0] norm_value;
      logic              end_of_run;
      logic              flat;
      logic              overflow;
   } rsp_payload_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] dividend;
      logic [DEV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quotient;
   } div_rsp_type;

endpackage

@@ rtl/lmrn_store.sv @@
// Sample store of the list mean/range normalizer: one write port, one registered read.
// Depends on lmrn_pkg for the capacity and sample width.
module lmrn_store (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [lmrn_pkg::ADDR_W-1:0]          wr_addr,
   input  logic [lmrn_pkg::SAMPLE_BITS-1:0]     wr_data,
   input  logic [lmrn_pkg::ADDR_W-1:0]          rd_addr,
   output logic [lmrn_pkg::SAMPLE_BITS-1:0]     rd_data
);

   logic [lmrn_pkg::SAMPLE_BITS-1:0] store_ff [lmrn_pkg::MAX_LEN];
   logic [lmrn_pkg::SAMPLE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/lmrn_divider.sv @@
// Serial restoring divider of the list mean/range normalizer, one quotient bit a cycle.
// Depends on lmrn_pkg for the operand widths and the request/response structs.
module lmrn_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  lmrn_pkg::div_req_type     div_req,
   output lmrn_pkg::div_rsp_type     div_rsp
);

   localparam int EXT_W = lmrn_pkg::NUM_W + lmrn_pkg::FRAC_SHIFT;
   localparam int HI_W  = EXT_W - lmrn_pkg::QUOT_W;

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [lmrn_pkg::STEP_W-1:0]       step_ff, step_in;
   logic [lmrn_pkg::DEV_W-1:0]        rem_ff, rem_in;
   logic [lmrn_pkg::DEV_W-1:0]        divisor_ff, divisor_in;
   logic [lmrn_pkg::QUOT_W-1:0]       low_ff, low_in;
   logic [lmrn_pkg::QUOT_W-1:0]       quot_ff, quot_in;

   logic [EXT_W-1:0]                  dividend_ext;
   logic [lmrn_pkg::DEV_W:0]          trial;
   logic [lmrn_pkg::DEV_W:0]          diff;
   logic                              fits;

   // The quotient is known to fit QUOT_W bits, so the high part of the shifted
   // dividend is already below the divisor and seeds the remainder.
   assign dividend_ext = {div_req.dividend, {lmrn_pkg::FRAC_SHIFT{1'b0}}};
   assign trial        = {rem_ff, low_ff[lmrn_pkg::QUOT_W-1]};
   assign diff         = trial - {1'b0, divisor_ff};
   assign fits         = (trial >= {1'b0, divisor_ff});

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      low_in     = low_ff;
      quot_in    = quot_ff;
      if (div_req.start && !busy_ff) begin
         busy_in    = 1'b1;
         step_in    = '0;
         rem_in     = lmrn_pkg::DEV_W'(dividend_ext[EXT_W-1 -: HI_W]);
         low_in     = dividend_ext[lmrn_pkg::QUOT_W-1:0];
         divisor_in = div_req.divisor;
         quot_in    = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[lmrn_pkg::DEV_W-1:0] : trial[lmrn_pkg::DEV_W-1:0];
         low_in  = {low_ff[lmrn_pkg::QUOT_W-2:0], 1'b0};
         quot_in = {quot_ff[lmrn_pkg::QUOT_W-2:0], fits};
         step_in = step_ff + lmrn_pkg::STEP_W'(1);
         if (step_ff == lmrn_pkg::STEP_W'(lmrn_pkg::QUOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      low_ff     <= low_in;
      quot_ff    <= quot_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

endmodule

@@ rtl/list_mean_range_normalizer.sv @@
// Top level of the list mean/range normalizer: load sequencer, shared multiplier,
// result register. Depends on lmrn_pkg, lmrn_store and lmrn_divider.
//
//   channel   | ports                          | transfer
//   ----------+--------------------------------+------------------------------------
//   request   | start, busy, req_data          | edge with start high and busy low
//   response  | rsp_strobe, rsp_data           | every cycle with rsp_strobe high
//
// A push that does not close a list leaves busy low.
// A closing push or a replay passes S_MUL_HI, S_MUL_LO and S_DEV for the
// deviation, then per element S_READ, S_MUL_X and S_NUM for fetch, multiply and
// numerator, and S_DIV (divider, one quotient bit a cycle) unless the list is flat.
// Synchronous reset returns to idle with no list; the store needs no clearing.
// The receiver cannot stall: each result is shown for exactly one cycle.
module list_mean_range_normalizer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  lmrn_pkg::req_payload_type   req_data,
   output logic                        rsp_strobe,
   output lmrn_pkg::rsp_payload_type   rsp_data
);

   localparam int SB = lmrn_pkg::SAMPLE_BITS;
   localparam int SW = lmrn_pkg::SUM_W;

   // Sequencer states, one-hot.
   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_MUL_HI = 8'b0000_0010,
      S_MUL_LO = 8'b0000_0100,
      S_DEV    = 8'b0000_1000,
      S_READ   = 8'b0001_0000,
      S_MUL_X  = 8'b0010_0000,
      S_NUM    = 8'b0100_0000,
      S_DIV    = 8'b1000_0000
   } seq_state_type;

   localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
   localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};

   seq_state_type                       state_ff, state_in;
   logic [lmrn_pkg::CNT_W-1:0]          load_count_ff, load_count_in;
   logic [lmrn_pkg::CNT_W-1:0]          list_length_ff, list_length_in;
   logic signed [SW-1:0]                sum_ff, sum_in;
   logic signed [SB-1:0]                min_ff, min_in;
   logic signed [SB-1:0]                max_ff, max_in;
   logic                                ovf_seen_ff, ovf_seen_in;
   logic                                list_ovf_ff, list_ovf_in;
   logic signed [SW-1:0]                prod_ff, prod_in;
   logic signed [SW-1:0]                dhi_ff, dhi_in;
   logic [lmrn_pkg::DEV_W-1:0]          dev_ff, dev_in;
   logic                                flat_ff, flat_in;
   logic [lmrn_pkg::ADDR_W-1:0]         idx_ff, idx_in;
   logic                                rsp_strobe_ff, rsp_strobe_in;
   lmrn_pkg::rsp_payload_type           rsp_data_ff, rsp_data_in;

   logic                                accept;
   logic                                has_room;
   logic signed [SW-1:0]                base_sum;
   logic signed [SB-1:0]                base_min;
   logic signed [SB-1:0]                base_max;
   logic                                base_ovf;
   logic signed [SB-1:0]                rd_sample;
   logic [SB-1:0]                       rd_data;
   logic signed [SB-1:0]                mul_op;
   logic signed [lmrn_pkg::CNT_W+SB:0]  mul_full;
   logic signed [SW-1:0]                dlo;
   logic signed [SW-1:0]                dev_sel;
   logic signed [SW+1:0]                num_wide;
   logic                                last_elem;
   logic                                wr_en;
   lmrn_pkg::div_req_type               div_req;
   lmrn_pkg::div_rsp_type               div_rsp;

   assign accept   = start && (state_ff == S_IDLE);
   assign has_room = (load_count_ff < lmrn_pkg::CNT_W'(lmrn_pkg::MAX_LEN));

   // The first push of a list starts from empty statistics.
   assign base_sum = (load_count_ff == '0) ? '0 : sum_ff;
   assign base_min = (load_count_ff == '0) ? SAMPLE_MAX : min_ff;
   assign base_max = (load_count_ff == '0) ? SAMPLE_MIN : max_ff;
   assign base_ovf = (load_count_ff == '0) ? 1'b0 : ovf_seen_ff;

   assign wr_en = accept && (req_data.req_type == lmrn_pkg::REQ_PUSH) && has_room;

   lmrn_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (load_count_ff[lmrn_pkg::ADDR_W-1:0]),
      .wr_data (req_data.sample),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign rd_sample = $signed(rd_data);

   // One multiplier by the list length serves the maximum, the minimum and
   // every stored element in turn.
   always_comb begin
      case (state_ff)
         S_MUL_HI: mul_op = max_ff;
         S_MUL_LO: mul_op = min_ff;
         default:  mul_op = rd_sample;
      endcase
   end

   assign mul_full = $signed({1'b0, list_length_ff}) * mul_op;

   assign dlo     = sum_ff - prod_ff;
   assign dev_sel = (dhi_ff > dlo) ? dhi_ff : dlo;

   // Numerator dev + n*x - sum never goes negative and never exceeds 2*dev.
   assign num_wide = $signed({{(SW+2-lmrn_pkg::DEV_W){1'b0}}, dev_ff})
                   + $signed({{2{prod_ff[SW-1]}}, prod_ff})
                   - $signed({{2{sum_ff[SW-1]}}, sum_ff});

   assign last_elem = ((lmrn_pkg::CNT_W'(idx_ff) + lmrn_pkg::CNT_W'(1)) == list_length_ff);

   assign div_req.start    = (state_ff == S_NUM) && !flat_ff;
   assign div_req.dividend = num_wide[lmrn_pkg::NUM_W-1:0];
   assign div_req.divisor  = dev_ff;

   lmrn_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      state_in       = state_ff;
      load_count_in  = load_count_ff;
      list_length_in = list_length_ff;
      sum_in         = sum_ff;
      min_in         = min_ff;
      max_in         = max_ff;
      ovf_seen_in    = ovf_seen_ff;
      list_ovf_in    = list_ovf_ff;
      prod_in        = prod_ff;
      dhi_in         = dhi_ff;
      dev_in         = dev_ff;
      flat_in        = flat_ff;
      idx_in         = idx_ff;
      rsp_strobe_in  = 1'b0;
      rsp_data_in    = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_data.req_type == lmrn_pkg::REQ_PUSH) begin
                  sum_in      = base_sum;
                  min_in      = base_min;
                  max_in      = base_max;
                  ovf_seen_in = base_ovf;
                  if (load_count_ff == '0) begin
                     list_length_in = '0;
                  end
                  if (has_room) begin
                     sum_in        = base_sum + $signed({{(SW-SB){req_data.sample[SB-1]}},
                                                         req_data.sample});
                     min_in        = (req_data.sample < base_min) ? req_data.sample : base_min;
                     max_in        = (req_data.sample > base_max) ? req_data.sample : base_max;
                     load_count_in = load_count_ff + lmrn_pkg::CNT_W'(1);
                  end else begin
                     ovf_seen_in = 1'b1;
                  end
                  if (req_data.last_flag) begin
                     list_length_in = has_room ? (load_count_ff + lmrn_pkg::CNT_W'(1))
                                               : load_count_ff;
                     list_ovf_in    = has_room ? base_ovf : 1'b1;
                     load_count_in  = '0;
                     state_in       = S_MUL_HI;
                  end
               end else if ((load_count_ff == '0) && (list_length_ff != '0)) begin
                  state_in = S_MUL_HI;
               end
            end
         end
         S_MUL_HI: begin
            prod_in  = mul_full[SW-1:0];
            state_in = S_MUL_LO;
         end
         S_MUL_LO: begin
            dhi_in   = prod_ff - sum_ff;
            prod_in  = mul_full[SW-1:0];
            state_in = S_DEV;
         end
         S_DEV: begin
            dev_in   = dev_sel[lmrn_pkg::DEV_W-1:0];
            flat_in  = (dev_sel == '0);
            idx_in   = '0;
            state_in = S_READ;
         end
         S_READ: begin
            state_in = S_MUL_X;
         end
         S_MUL_X: begin
            prod_in  = mul_full[SW-1:0];
            state_in = S_NUM;
         end
         S_NUM: begin
            if (flat_ff) begin
               rsp_strobe_in          = 1'b1;
               rsp_data_in.norm_value = lmrn_pkg::NORM_MID;
               rsp_data_in.end_of_run = last_elem;
               rsp_data_in.flat       = 1'b1;
               rsp_data_in.overflow   = list_ovf_ff;
               idx_in                 = idx_ff + lmrn_pkg::ADDR_W'(1);
               state_in               = last_elem ? S_IDLE : S_READ;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               rsp_strobe_in          = 1'b1;
               // A quotient of exactly one full scale saturates.
               rsp_data_in.norm_value = div_rsp.quotient[lmrn_pkg::QUOT_W-1]
                                      ? '1 : div_rsp.quotient[lmrn_pkg::NORM_W-1:0];
               rsp_data_in.end_of_run = last_elem;
               rsp_data_in.flat       = 1'b0;
               rsp_data_in.overflow   = list_ovf_ff;
               idx_in                 = idx_ff + lmrn_pkg::ADDR_W'(1);
               state_in               = last_elem ? S_IDLE : S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         load_count_ff  <= '0;
         list_length_ff <= '0;
         sum_ff         <= '0;
         min_ff         <= SAMPLE_MAX;
         max_ff         <= SAMPLE_MIN;
         ovf_seen_ff    <= 1'b0;
         list_ovf_ff    <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         load_count_ff  <= load_count_in;
         list_length_ff <= list_length_in;
         sum_ff         <= sum_in;
         min_ff         <= min_in;
         max_ff         <= max_in;
         ovf_seen_ff    <= ovf_seen_in;
         list_ovf_ff    <= list_ovf_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
      prod_ff     <= prod_in;
      dhi_ff      <= dhi_in;
      dev_ff      <= dev_in;
      flat_ff     <= flat_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

@@ rtl/lmrn_checker.sv @@
// Port-level checker of the list mean/range normalizer, bound to the top level.
// Depends on lmrn_pkg and the assertion macros in list_mean_range_normalizer_assert.svh.
`include "list_mean_range_normalizer_assert.svh"

module lmrn_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input lmrn_pkg::req_payload_type   req_data,
   input logic                        rsp_strobe,
   input lmrn_pkg::rsp_payload_type   rsp_data
);

   logic push_open;
   logic push_close;

   assign push_open  = start && !busy && (req_data.req_type == lmrn_pkg::REQ_PUSH)
                    && !req_data.last_flag;
   assign push_close = start && !busy && (req_data.req_type == lmrn_pkg::REQ_PUSH)
                    && req_data.last_flag;

   `LMRN_ASSERT_ALWAYS(a_reset_idle, $past(reset) == 1'b1, !busy && !rsp_strobe, "not idle after reset")
   `LMRN_ASSERT_NEXT(a_push_quiet, push_open, !busy && !rsp_strobe, "push without last caused activity")
   `LMRN_ASSERT_NEXT(a_close_busy, push_close, busy, "closing push did not start emission")
   `LMRN_ASSERT_NOW(a_flat_mid, rsp_strobe && rsp_data.flat, rsp_data.norm_value == lmrn_pkg::NORM_MID, "flat result not at midpoint")
   `LMRN_ASSERT_NOW(a_run_end, rsp_strobe, busy == !rsp_data.end_of_run, "end of run does not match release of busy")

endmodule

bind list_mean_range_normalizer lmrn_checker u_checker (.*);
